// File: hw/rtl/ttcf_pkg.sv
// shared types, constants and fold arithmetic for the coordinate fold block
// no dependencies

package ttcf_pkg;

    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 8;
    localparam int SIZE_W    = 21;
    localparam int VAL_W     = COORD_W + 2;
    localparam int DIV_W     = COORD_W + 1;
    localparam int ADDR_W    = 4;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int POL_W     = 2;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HORIZ_POL  = 2'd2;
    localparam logic [1:0] REG_VERT_POL   = 2'd3;

    localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } in_beat_t;

    typedef struct packed {
        logic [SIZE_W-1:0] fixed_x;
        logic [SIZE_W-1:0] fixed_y;
        logic              horiz_mirrored;
        logic              vert_mirrored;
    } out_beat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic                    xm;
        logic                    ym;
        logic                    in_map;
    } item_t;

    typedef struct packed {
        logic [DIV_W-1:0]  dvd;
        logic [SIZE_W-1:0] rem;
        logic              q;
        logic              over;
        logic              active;
    } lane_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] v;
        logic                    odd;
    } fold_res_t;

    typedef struct packed {
        logic odd_x;
        logic odd_y;
    } odd_t;

    function automatic lane_t lane_prep(logic signed [VAL_W-1:0] v,
                                        logic [SIZE_W-1:0] span, logic en);
        lane_t                   l;
        logic signed [VAL_W-1:0] s;
        logic signed [VAL_W-1:0] d;
        logic                    under;
        s = $signed({{(VAL_W-SIZE_W){1'b0}}, span});
        l.over = (v > s);
        under  = v[VAL_W-1];
        d = l.over ? v - VAL_W'(1) : -v;
        l.dvd = d[DIV_W-1:0];
        l.rem = '0;
        l.q   = 1'b0;
        l.active = en && (span != '0) && (l.over || under);
        return l;
    endfunction

    // one restoring division step, quotient bit kept for parity only
    function automatic lane_t lane_step(lane_t l, logic [SIZE_W-1:0] span);
        lane_t         r;
        logic [SIZE_W:0] t;
        r = l;
        t = {l.rem, l.dvd[DIV_W-1]};
        r.dvd = l.dvd << 1;
        if (t >= {1'b0, span}) begin
            r.rem = SIZE_W'(t - {1'b0, span});
            r.q   = 1'b1;
        end else begin
            r.rem = t[SIZE_W-1:0];
            r.q   = 1'b0;
        end
        return r;
    endfunction

    function automatic fold_res_t lane_done(lane_t l, logic signed [VAL_W-1:0] v,
                                            logic [SIZE_W-1:0] span);
        fold_res_t f;
        logic      nz;
        nz = (l.rem != '0);
        if (!l.active) begin
            f.v   = v;
            f.odd = 1'b0;
        end else if (l.over) begin
            f.v   = $signed(VAL_W'(l.rem) + VAL_W'(1));
            f.odd = l.q;
        end else begin
            f.v   = nz ? $signed(VAL_W'(span) - VAL_W'(l.rem)) : '0;
            f.odd = l.q ^ nz;
        end
        return f;
    endfunction

endpackage

// File: hw/rtl/ttcf_queue.sv
// short item queue between the front and back parts
// depends on ttcf_pkg

module ttcf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ttcf_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output ttcf_pkg::item_t head
);

    ttcf_pkg::item_t             mem_reg [ttcf_pkg::Q_DEPTH];
    logic [ttcf_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ttcf_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ttcf_pkg::Q_AW:0]     count_reg, count_next;

    assign full      = (count_reg == (ttcf_pkg::Q_AW+1)'(ttcf_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (ttcf_pkg::Q_AW+1)'(push) - (ttcf_pkg::Q_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/ttcf_front.sv
// front part: takes input beats, flags points inside the map, feeds the queue
// depends on ttcf_pkg

module ttcf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ttcf_pkg::in_beat_t            s_beat,
    input  logic [ttcf_pkg::SIZE_W-1:0]   map_w,
    input  logic [ttcf_pkg::SIZE_W-1:0]   map_h,
    input  logic                          q_full,
    output logic                          q_push,
    output ttcf_pkg::item_t               q_item
);

    logic            hold_valid_reg, hold_valid_next;
    ttcf_pkg::item_t hold_item_reg, hold_item_next;
    logic signed [ttcf_pkg::VAL_W-1:0] x, y, ws, hs;

    assign q_push  = hold_valid_reg && !q_full;
    assign s_ready = !hold_valid_reg || !q_full;
    assign q_item  = hold_item_reg;

    always_comb begin
        x  = ttcf_pkg::VAL_W'(s_beat.pos_x);
        y  = ttcf_pkg::VAL_W'(s_beat.pos_y);
        ws = $signed(ttcf_pkg::VAL_W'(map_w));
        hs = $signed(ttcf_pkg::VAL_W'(map_h));
        hold_item_next.x  = x;
        hold_item_next.y  = y;
        hold_item_next.xm = 1'b0;
        hold_item_next.ym = 1'b0;
        hold_item_next.in_map = !(x[ttcf_pkg::VAL_W-1] || y[ttcf_pkg::VAL_W-1]
                                  || x > ws || y > hs);
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
        end else if (q_push) begin
            hold_valid_next = 1'b0;
        end else begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_item_reg <= hold_item_next;
        end
    end

endmodule

// File: hw/rtl/ttcf_fold.sv
// pipelined two-lane fold unit, one quotient bit per stage
// depends on ttcf_pkg

module ttcf_fold (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  ttcf_pkg::item_t               in_item,
    input  logic                          en_x,
    input  logic                          en_y,
    input  logic [ttcf_pkg::SIZE_W-1:0]   map_w,
    input  logic [ttcf_pkg::SIZE_W-1:0]   map_h,
    output logic                          out_valid,
    output ttcf_pkg::item_t               out_item,
    output ttcf_pkg::odd_t                out_odd
);

    localparam int NS = ttcf_pkg::DIV_W + 1;

    logic            vld_reg  [NS];
    ttcf_pkg::item_t item_reg [NS];
    ttcf_pkg::lane_t lx_reg   [NS];
    ttcf_pkg::lane_t ly_reg   [NS];

    logic            out_valid_reg;
    ttcf_pkg::item_t out_item_reg, out_item_next;
    ttcf_pkg::odd_t  out_odd_reg, out_odd_next;
    ttcf_pkg::fold_res_t fx, fy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[0] <= in_item;
            lx_reg[0]   <= ttcf_pkg::lane_prep(in_item.x, map_w, en_x);
            ly_reg[0]   <= ttcf_pkg::lane_prep(in_item.y, map_h, en_y);
            for (int i = 1; i < NS; i++) begin
                item_reg[i] <= item_reg[i-1];
                lx_reg[i]   <= ttcf_pkg::lane_step(lx_reg[i-1], map_w);
                ly_reg[i]   <= ttcf_pkg::lane_step(ly_reg[i-1], map_h);
            end
            out_item_reg <= out_item_next;
            out_odd_reg  <= out_odd_next;
        end
    end

    always_comb begin
        fx = ttcf_pkg::lane_done(lx_reg[NS-1], item_reg[NS-1].x, map_w);
        fy = ttcf_pkg::lane_done(ly_reg[NS-1], item_reg[NS-1].y, map_h);
        out_item_next   = item_reg[NS-1];
        out_item_next.x = fx.v;
        out_item_next.y = fy.v;
        out_odd_next.odd_x = fx.odd;
        out_odd_next.odd_y = fy.odd;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_odd   = out_odd_reg;

endmodule

// File: hw/rtl/ttcf_back.sv
// back part: two fold passes with mirroring, final clamp, output register
// depends on ttcf_pkg, ttcf_fold

module ttcf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ttcf_pkg::item_t               q_head,
    output logic                          q_pop,
    input  logic [ttcf_pkg::SIZE_W-1:0]   map_w,
    input  logic [ttcf_pkg::SIZE_W-1:0]   map_h,
    input  logic [ttcf_pkg::POL_W-1:0]    h_pol,
    input  logic [ttcf_pkg::POL_W-1:0]    v_pol,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ttcf_pkg::out_beat_t           m_beat
);

    logic                adv;
    logic                p1_valid, p2_valid;
    ttcf_pkg::item_t     p1_item, p2_in, p2_item;
    ttcf_pkg::odd_t      p1_odd, p2_odd;
    logic                p1_en_x, p1_en_y, p2_en_y;
    logic signed [ttcf_pkg::VAL_W-1:0] fx, ws, hs;
    logic                m_valid_reg, m_valid_next;
    ttcf_pkg::out_beat_t m_beat_reg, m_beat_next;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = q_valid && adv;
    assign ws    = $signed(ttcf_pkg::VAL_W'(map_w));
    assign hs    = $signed(ttcf_pkg::VAL_W'(map_h));

    // pass one folds x for any nonzero rule and y for plain wrap
    assign p1_en_x = !q_head.in_map && (h_pol != '0);
    assign p1_en_y = !q_head.in_map && (v_pol == 2'b01);

    ttcf_fold u_pass1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (q_valid),
        .in_item   (q_head),
        .en_x      (p1_en_x),
        .en_y      (p1_en_y),
        .map_w     (map_w),
        .map_h     (map_h),
        .out_valid (p1_valid),
        .out_item  (p1_item),
        .out_odd   (p1_odd)
    );

    always_comb begin
        p2_in = p1_item;
        if (h_pol[1] && p1_odd.odd_x) begin
            p2_in.y  = hs - ttcf_pkg::ONE - p1_item.y;
            p2_in.ym = !p1_item.ym;
        end
    end

    assign p2_en_y = !p1_item.in_map && v_pol[1];

    ttcf_fold u_pass2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (p1_valid),
        .in_item   (p2_in),
        .en_x      (1'b0),
        .en_y      (p2_en_y),
        .map_w     (map_w),
        .map_h     (map_h),
        .out_valid (p2_valid),
        .out_item  (p2_item),
        .out_odd   (p2_odd)
    );

    always_comb begin
        fx = p2_item.x;
        m_beat_next.horiz_mirrored = p2_item.xm;
        if (v_pol[1] && p2_odd.odd_y) begin
            fx = ws - ttcf_pkg::ONE - p2_item.x;
            m_beat_next.horiz_mirrored = !p2_item.xm;
        end
        m_beat_next.vert_mirrored = p2_item.ym;
        if (fx[ttcf_pkg::VAL_W-1]) begin
            m_beat_next.fixed_x = '0;
        end else if (fx > ws) begin
            m_beat_next.fixed_x = map_w;
        end else begin
            m_beat_next.fixed_x = fx[ttcf_pkg::SIZE_W-1:0];
        end
        if (p2_item.y[ttcf_pkg::VAL_W-1]) begin
            m_beat_next.fixed_y = '0;
        end else if (p2_item.y > hs) begin
            m_beat_next.fixed_y = map_h;
        end else begin
            m_beat_next.fixed_y = p2_item.y[ttcf_pkg::SIZE_W-1:0];
        end
        m_valid_next = adv ? p2_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_beat_reg <= m_beat_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

endmodule

// File: hw/rtl/twisted_torus_coord_fix.sv
// coordinate fold top level: config registers, front, queue and back parts
// path: the front hold register into the queue, then in the back two passes of 26 divider
// stages and an output reg each, then the m_beat register
// throughput: one beat per cycle while m_ready does not hold the output, set by the fully pipelined fold passes
// reset: synchronous active low; size registers to 65536, polarities to clamp
// depends on ttcf_pkg, ttcf_front, ttcf_queue, ttcf_fold, ttcf_back

module twisted_torus_coord_fix (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ttcf_pkg::in_beat_t            s_beat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ttcf_pkg::out_beat_t           m_beat,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttcf_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [ttcf_pkg::SIZE_W-1:0] map_w_reg, map_w_next;
    logic [ttcf_pkg::SIZE_W-1:0] map_h_reg, map_h_next;
    logic [ttcf_pkg::POL_W-1:0]  h_pol_reg, h_pol_next;
    logic [ttcf_pkg::POL_W-1:0]  v_pol_reg, v_pol_next;
    logic                        wr_en;
    logic [1:0]                  reg_sel;

    logic            q_full, q_push, q_pop, q_valid;
    ttcf_pkg::item_t q_item, q_head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_comb begin
        map_w_next = map_w_reg;
        map_h_next = map_h_reg;
        h_pol_next = h_pol_reg;
        v_pol_next = v_pol_reg;
        if (wr_en) begin
            unique case (reg_sel)
                ttcf_pkg::REG_MAP_WIDTH:  map_w_next = pwdata[ttcf_pkg::SIZE_W-1:0];
                ttcf_pkg::REG_MAP_HEIGHT: map_h_next = pwdata[ttcf_pkg::SIZE_W-1:0];
                ttcf_pkg::REG_HORIZ_POL:  h_pol_next = pwdata[ttcf_pkg::POL_W-1:0];
                ttcf_pkg::REG_VERT_POL:   v_pol_next = pwdata[ttcf_pkg::POL_W-1:0];
                default: ;
            endcase
        end
        unique case (reg_sel)
            ttcf_pkg::REG_MAP_WIDTH:  prdata = 32'(map_w_reg);
            ttcf_pkg::REG_MAP_HEIGHT: prdata = 32'(map_h_reg);
            ttcf_pkg::REG_HORIZ_POL:  prdata = 32'(h_pol_reg);
            ttcf_pkg::REG_VERT_POL:   prdata = 32'(v_pol_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_w_reg <= ttcf_pkg::SIZE_W'(65536);
            map_h_reg <= ttcf_pkg::SIZE_W'(65536);
            h_pol_reg <= '0;
            v_pol_reg <= '0;
        end else begin
            map_w_reg <= map_w_next;
            map_h_reg <= map_h_next;
            h_pol_reg <= h_pol_next;
            v_pol_reg <= v_pol_next;
        end
    end

    ttcf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .map_w   (map_w_reg),
        .map_h   (map_h_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_item)
    );

    ttcf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    ttcf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .map_w   (map_w_reg),
        .map_h   (map_h_reg),
        .h_pol   (h_pol_reg),
        .v_pol   (v_pol_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

    // queue never written while full
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("push into full queue");

    // pop only when the queue holds something
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("pop from empty queue");

    // output empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a full queue with a blocked back end and a stalled front cannot drain without a pop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_full && !q_pop && !s_ready) |=> (q_full || q_pop))
        else $error("queue drained without pop");

endmodule

// File: test/testbench.sv
// testbench for twisted_torus_coord_fix: directed and random points under several map setups
// depends on ttcf_pkg and the twisted_torus_coord_fix rtl

module testbench;

    localparam int  HALF_PERIOD = 5;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 100;
    localparam int  HOLD_CYCLES = 300;
    localparam int  IDLE_PCT    = 22;
    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;

    // folds points with the same edge rules as the block and checks its beats
    class fold_scoreboard;
        longint    width_q, height_q;
        int        hpol, vpol;
        ttcf_pkg::out_beat_t pending_q[$];
        int        errors;

        function void reset_regs();
            width_q = 65536;
            height_q = 65536;
            hpol = 0;
            vpol = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                ttcf_pkg::REG_MAP_WIDTH:
                    width_q = longint'(value[ttcf_pkg::SIZE_W-1:0]);
                ttcf_pkg::REG_MAP_HEIGHT:
                    height_q = longint'(value[ttcf_pkg::SIZE_W-1:0]);
                ttcf_pkg::REG_HORIZ_POL: hpol = int'($signed(value[1:0]));
                ttcf_pkg::REG_VERT_POL: vpol = int'($signed(value[1:0]));
                default: ;
            endcase
        endfunction

        function longint wrap_axis(longint v, longint span, output bit odd);
            longint k;
            k = 0;
            odd = 0;
            if (span <= 0) return v;
            if (v > span) begin
                k = (v - 1) / span;
                v -= k * span;
            end else if (v < 0) begin
                k = (-v + span - 1) / span;
                v += k * span;
            end
            odd = k[0];
            return v;
        endfunction

        function void note_input(ttcf_pkg::in_beat_t b);
            longint    x, y, one;
            bit        xm, ym, odd;
            ttcf_pkg::out_beat_t e;
            one = 64'sd1 << ttcf_pkg::FRAC_BITS;
            x = longint'(b.pos_x);
            y = longint'(b.pos_y);
            xm = 0;
            ym = 0;
            if (x < 0 || y < 0 || x > width_q || y > height_q) begin
                if (hpol > 0) x = wrap_axis(x, width_q, odd);
                if (vpol > 0) y = wrap_axis(y, height_q, odd);
                if (hpol < 0) begin
                    x = wrap_axis(x, width_q, odd);
                    if (odd) begin
                        y = height_q - one - y;
                        ym = !ym;
                    end
                end
                if (vpol < 0) begin
                    y = wrap_axis(y, height_q, odd);
                    if (odd) begin
                        x = width_q - one - x;
                        xm = !xm;
                    end
                end
                if (x < 0) x = 0;
                if (x > width_q) x = width_q;
                if (y < 0) y = 0;
                if (y > height_q) y = height_q;
            end
            e.fixed_x = x[ttcf_pkg::SIZE_W-1:0];
            e.fixed_y = y[ttcf_pkg::SIZE_W-1:0];
            e.horiz_mirrored = xm;
            e.vert_mirrored = ym;
            pending_q.push_back(e);
        endfunction

        function void check_result(ttcf_pkg::out_beat_t got);
            ttcf_pkg::out_beat_t e;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.fixed_x !== e.fixed_x) begin
                $error("fixed_x expected %0d got %0d", e.fixed_x, got.fixed_x);
                errors++;
            end
            if (got.fixed_y !== e.fixed_y) begin
                $error("fixed_y expected %0d got %0d", e.fixed_y, got.fixed_y);
                errors++;
            end
            if (got.horiz_mirrored !== e.horiz_mirrored) begin
                $error("horiz_mirrored expected %0b got %0b",
                       e.horiz_mirrored, got.horiz_mirrored);
                errors++;
            end
            if (got.vert_mirrored !== e.vert_mirrored) begin
                $error("vert_mirrored expected %0b got %0b",
                       e.vert_mirrored, got.vert_mirrored);
                errors++;
            end
        endfunction
    endclass

    logic                        aclk = 0;
    logic                        aresetn = 0;
    logic                        s_valid = 0;
    logic                        s_ready;
    ttcf_pkg::in_beat_t          s_beat = '0;
    logic                        m_valid;
    logic                        m_ready = 0;
    ttcf_pkg::out_beat_t         m_beat;
    logic                        psel = 0;
    logic                        penable = 0;
    logic                        pwrite = 0;
    logic [ttcf_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    fold_scoreboard sb = new();
    int  cycle_cnt = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;
    int  hold_left = 0;

    twisted_torus_coord_fix DUT (.*);

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("twisted_torus_coord_fix regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_beat);
        if (aresetn && m_valid && m_ready) sb.check_result(m_beat);
    end

    // result side: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ttcf_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_map(logic [31:0] w, logic [31:0] h, logic [1:0] hp, logic [1:0] vp);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        reg_write(ttcf_pkg::REG_MAP_WIDTH, w);
        reg_write(ttcf_pkg::REG_MAP_HEIGHT, h);
        reg_write(ttcf_pkg::REG_HORIZ_POL, {30'd0, hp});
        reg_write(ttcf_pkg::REG_VERT_POL, {30'd0, vp});
    endtask

    // sender: optional idle cycles, then hold the beat until it is taken
    task automatic send_point(longint x, longint y);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_beat.pos_x <= x[ttcf_pkg::COORD_W-1:0];
        s_beat.pos_y <= y[ttcf_pkg::COORD_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic longint pick_coord(longint span);
        longint k;
        case ($urandom_range(5))
            0: return longint'($urandom_range(span > 0 ? span : 0));
            1: return longint'($signed($urandom()) >>> 8);
            2: return longint'($urandom_range(6)) - 3;
            3: return span + longint'($urandom_range(6)) - 3;
            4: begin
                k = longint'($urandom_range(8)) - 4;
                return k * span + longint'($urandom_range(4)) - 2;
            end
            default: return $urandom_range(1) ? COORD_MAX - $urandom_range(3)
                                               : COORD_MIN + $urandom_range(3);
        endcase
    endfunction

    task automatic random_points(int n);
        longint px, py;
        repeat (n) begin
            px = pick_coord(sb.width_q);
            py = pick_coord(sb.height_q);
            if (px > COORD_MAX) px = COORD_MAX;
            if (px < COORD_MIN) px = COORD_MIN;
            if (py > COORD_MAX) py = COORD_MAX;
            if (py < COORD_MIN) py = COORD_MIN;
            send_point(px, py);
        end
        end_burst();
    endtask

    task automatic directed_points();
        longint w, h;
        w = sb.width_q;
        h = sb.height_q;
        send_point(0, 0);
        send_point(w, h);
        send_point(-1, -1);
        send_point(w + 1, h + 1);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);
        send_point(2 * w + 1, -2 * h);
        send_point(-w, 3 * h + 5);
        send_point(w / 2, -h - 1);
        send_point(-5 * w, h / 2);
        send_point(COORD_MAX, 0);
        end_burst();
    endtask

    initial begin
        sb.reset_regs();
        sb.errors = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setup: clamp on both axes
        directed_points();
        random_points(100);

        // wrap with mirror on both axes
        set_map(1000, 2000, 2'b11, 2'b11);
        directed_points();
        random_points(150);

        // smallest legal map, plain wrap, then a full stall of the result side
        set_map(256, 256, 2'b01, 2'b01);
        hold_req = 1;
        random_points(150);

        // 1048576 by 1048576 map with mirror, no idling anywhere
        set_map(1048576, 1048576, 2'b11, 2'b11);
        no_idle = 1;
        random_points(150);
        no_idle = 0;

        // mixed rules, code -2 counts as mirror wrap
        set_map(300, 70000, 2'b10, 2'b01);
        random_points(120);
        wait_drained();
        random_points(30);

        // zero width skips the x wrap; height wraps with mirror
        set_map(0, 5000, 2'b01, 2'b11);
        random_points(150);

        // size below one unit makes mirroring go negative
        set_map(100, 200, 2'b11, 2'b10);
        random_points(150);

        // high register bits are dropped by the size mask
        set_map(32'hFFFF_FFFF, 32'hFFE1_2345, 2'b11, 2'b00);
        random_points(150);

        // random setups
        repeat (3) begin
            set_map($urandom_range(1048576, 256), $urandom_range(1048576, 256),
                    2'($urandom_range(3)), 2'($urandom_range(3)));
            random_points(40);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("twisted_torus_coord_fix regression: pass");
        end else begin
            $display("twisted_torus_coord_fix regression: fail");
        end
        $finish;
    end

endmodule
